@@ sv/fcta_pkg.sv @@
// fcta_pkg: shared constants, types and check/trailer functions for the
// frame check trailer appender. No dependencies.
package fcta_pkg;

  // delay line sizing
  localparam int MAX_TAIL = 16;
  localparam int DEPTH    = MAX_TAIL + 1;
  localparam int PTR_W    = $clog2(DEPTH);
  localparam int FILL_W   = $clog2(DEPTH + 1);
  localparam int TAIL_W   = 5;
  localparam int ADDR_W   = 4;

  // check constants
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;
  localparam logic [7:0]  ASCII_STAR = 8'h2A;
  localparam logic [7:0]  ASCII_ZERO = 8'h30;
  localparam logic [7:0]  ASCII_A    = 8'h41;
  localparam logic [7:0]  ASCII_CR   = 8'h0D;
  localparam logic [7:0]  ASCII_LF   = 8'h0A;

  typedef enum logic [1:0] {
    MODE_CRC16   = 2'd0,
    MODE_XOR     = 2'd1,
    MODE_LRC     = 2'd2,
    MODE_XOR_HEX = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_CHECK_MODE = 2'd0,
    REG_SKIP_HEAD  = 2'd1,
    REG_SKIP_TAIL  = 2'd2
  } reg_idx_t;

  typedef enum logic {
    ST_RUN,
    ST_DRAIN
  } dl_state_t;

  typedef struct packed {
    mode_t             mode;
    logic [7:0]        skip_head;
    logic [TAIL_W-1:0] skip_tail;
  } cfg_t;

  // one step of the delay line toward the check unit
  typedef struct packed {
    logic       valid;
    logic       has_byte;
    logic [7:0] data;
    logic       end_frame;
    logic       rel;
    logic       absorb;
    logic       forward;
  } rel_op_t;

  typedef struct packed {
    logic              draining;
    logic [FILL_W-1:0] fill;
  } dl_stat_t;

  // one output job: pass byte and/or trailer
  typedef struct packed {
    logic        valid;
    logic        has_byte;
    logic [7:0]  data;
    logic        end_frame;
    mode_t       mode;
    logic [15:0] value;
  } emit_job_t;

  function automatic logic [15:0] init_value(mode_t mode);
    return (mode == MODE_CRC16) ? CRC_INIT : 16'h0000;
  endfunction

  // byte-wide reflected crc update, eight shift steps
  function automatic logic [15:0] crc16_byte(logic [15:0] acc, logic [7:0] b);
    logic [15:0] c;
    c = acc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [15:0] absorb_byte(mode_t mode, logic [15:0] acc,
                                              logic [7:0] b);
    logic [15:0] r;
    case (mode)
      MODE_CRC16: r = crc16_byte(acc, b);
      MODE_LRC:   r = {8'h00, acc[7:0] + b};
      default:    r = {8'h00, acc[7:0] ^ b};
    endcase
    return r;
  endfunction

  function automatic logic [7:0] hex_digit(logic [3:0] n);
    return (n < 4'd10) ? (ASCII_ZERO + {4'h0, n})
                       : (ASCII_A + {4'h0, n} - 8'd10);
  endfunction

  function automatic logic [2:0] trailer_len(mode_t mode);
    logic [2:0] r;
    case (mode)
      MODE_CRC16:   r = 3'd2;
      MODE_XOR_HEX: r = 3'd5;
      default:      r = 3'd1;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] trailer_byte(mode_t mode, logic [15:0] value,
                                              logic [2:0] idx);
    logic [7:0] r;
    case (mode)
      MODE_CRC16: r = (idx == 3'd0) ? value[15:8] : value[7:0];
      MODE_XOR:   r = value[7:0];
      MODE_LRC:   r = 8'h00 - value[7:0];
      default: begin
        case (idx)
          3'd0:    r = ASCII_STAR;
          3'd1:    r = hex_digit(value[7:4]);
          3'd2:    r = hex_digit(value[3:0]);
          3'd3:    r = ASCII_CR;
          default: r = ASCII_LF;
        endcase
      end
    endcase
    return r;
  endfunction

endpackage

@@ sv/fcta_in_if.sv @@
// fcta_in_if: input word channel (frame byte and end marker) with
// valid/ready handshake. No dependencies.
interface fcta_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_end;

  modport source (output valid, output data_byte, output frame_end, input ready);
  modport sink (input valid, input data_byte, input frame_end, output ready);
endinterface

@@ sv/fcta_out_if.sv @@
// fcta_out_if: output word channel (byte and last marker) with
// valid/ready handshake. No dependencies.
interface fcta_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

@@ sv/fcta_delay_line.sv @@
// fcta_delay_line: circular tail delay memory with write/read pointers,
// fill count, frame index and drain sequencer. Depends on fcta_pkg.
module fcta_delay_line import fcta_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       in_valid,
  input  logic [7:0] in_data,
  input  logic       in_end,
  output logic       in_ready,
  input  logic       adv,
  output rel_op_t    op,
  output logic [7:0] rd_data,
  output dl_stat_t   stat
);

  logic [7:0]        mem [DEPTH];
  logic [PTR_W-1:0]  wp, wp_next;
  logic [PTR_W-1:0]  rp, rp_next;
  logic [FILL_W-1:0] fill, fill_next;
  logic [7:0]        idx, idx_next;
  logic              pend_end, pend_end_next;
  dl_state_t         st, st_next;
  logic              mem_we;
  logic              rd_en;
  logic [FILL_W-1:0] tail;
  logic [FILL_W-1:0] fill_inc;
  logic              accept;

  function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // effective tail length, capped at the delay capacity
  assign tail = (FILL_W'(cfg.skip_tail) > FILL_W'(MAX_TAIL)) ? FILL_W'(MAX_TAIL)
                                                            : FILL_W'(cfg.skip_tail);
  assign fill_inc = fill + 1'b1;
  assign in_ready = (st == ST_RUN) && adv;
  assign accept   = in_valid && in_ready;

  // next state, pointer updates and the op handed to the check unit
  always_comb begin
    st_next       = st;
    wp_next       = wp;
    rp_next       = rp;
    fill_next     = fill;
    idx_next      = idx;
    pend_end_next = pend_end;
    mem_we        = 1'b0;
    rd_en         = 1'b0;
    op            = '0;
    unique case (st)
      ST_RUN: begin
        if (accept) begin
          mem_we      = 1'b1;
          wp_next     = ptr_inc(wp);
          op.valid    = 1'b1;
          op.has_byte = 1'b1;
          op.data     = in_data;
          if (fill_inc > tail) begin
            op.rel     = 1'b1;
            op.absorb  = (idx >= cfg.skip_head);
            op.forward = (fill == '0);
            rd_en      = (fill != '0);
            rp_next    = ptr_inc(rp);
            idx_next   = (idx == 8'hFF) ? idx : idx + 8'd1;
            fill_next  = fill;
            if (fill > tail) begin
              st_next       = ST_DRAIN;
              pend_end_next = in_end;
            end else begin
              op.end_frame = in_end;
            end
          end else begin
            fill_next    = fill_inc;
            op.end_frame = in_end;
          end
          if (op.end_frame) begin
            fill_next = '0;
            wp_next   = '0;
            rp_next   = '0;
            idx_next  = '0;
          end
        end
      end
      ST_DRAIN: begin
        if (adv) begin
          op.valid  = 1'b1;
          op.rel    = 1'b1;
          op.absorb = (idx >= cfg.skip_head);
          rd_en     = 1'b1;
          rp_next   = ptr_inc(rp);
          fill_next = fill - 1'b1;
          idx_next  = (idx == 8'hFF) ? idx : idx + 8'd1;
          if ((fill - 1'b1) == tail) begin
            st_next      = ST_RUN;
            op.end_frame = pend_end;
            if (pend_end) begin
              fill_next = '0;
              wp_next   = '0;
              rp_next   = '0;
              idx_next  = '0;
            end
          end
        end
      end
      default: st_next = ST_RUN;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= ST_RUN;
      wp       <= '0;
      rp       <= '0;
      fill     <= '0;
      idx      <= '0;
      pend_end <= 1'b0;
    end else begin
      st       <= st_next;
      wp       <= wp_next;
      rp       <= rp_next;
      fill     <= fill_next;
      idx      <= idx_next;
      pend_end <= pend_end_next;
    end
  end

  // delay memory, read data registered
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wp] <= in_data;
    end
    if (rd_en) begin
      rd_data <= mem[rp];
    end
  end

  assign stat.draining = (st == ST_DRAIN);
  assign stat.fill     = fill;

endmodule

@@ sv/fcta_check_unit.sv @@
// fcta_check_unit: release stage holding the check accumulator; absorbs
// released bytes and forms output jobs. Depends on fcta_pkg.
module fcta_check_unit import fcta_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  mode_t       mode,
  input  logic        mode_wr,
  input  mode_t       wr_mode,
  input  rel_op_t     op_in,
  input  logic [7:0]  rd_data,
  input  logic        out_free,
  output logic        adv,
  output emit_job_t   job,
  output logic [15:0] acc_out
);

  rel_op_t     b_op;
  logic [15:0] acc;
  logic [15:0] acc_after;
  logic [7:0]  rel_byte;
  logic        emits;
  logic        fire;

  // stage control
  assign emits = b_op.has_byte || b_op.end_frame;
  assign fire  = b_op.valid && (!emits || out_free);
  assign adv   = !b_op.valid || fire;

  // released byte comes from memory or straight from the input word
  assign rel_byte  = b_op.forward ? b_op.data : rd_data;
  assign acc_after = (b_op.rel && b_op.absorb) ? absorb_byte(mode, acc, rel_byte) : acc;

  // job for the output stage
  always_comb begin
    job.valid     = fire && emits;
    job.has_byte  = b_op.has_byte;
    job.data      = b_op.data;
    job.end_frame = b_op.end_frame;
    job.mode      = mode;
    job.value     = acc_after;
  end

  // stage register and accumulator, a mode write starts from the new mode
  always_ff @(posedge clk) begin
    if (rst) begin
      b_op.valid <= 1'b0;
      acc        <= CRC_INIT;
    end else begin
      if (adv) begin
        b_op <= op_in;
      end
      if (mode_wr) begin
        acc <= init_value(wr_mode);
      end else if (fire) begin
        acc <= b_op.end_frame ? init_value(mode) : acc_after;
      end
    end
  end

  assign acc_out = acc;

endmodule

@@ sv/fcta_out_emit.sv @@
// fcta_out_emit: output register stage; sends the pass byte of one job, if
// any, and then, for a frame end, its trailer bytes. Depends on fcta_pkg.
module fcta_out_emit import fcta_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  emit_job_t job,
  output logic      out_free,
  output logic      out_valid,
  input  logic      out_ready,
  output logic [7:0] out_byte,
  output logic      out_last
);

  logic      o_valid;
  emit_job_t o_job;
  logic      o_phase_byte;
  logic [2:0] o_tidx;
  logic      tr_last;
  logic      done_cur;
  logic      take;

  assign tr_last  = (o_tidx == (trailer_len(o_job.mode) - 3'd1));
  assign done_cur = o_phase_byte ? !o_job.end_frame : tr_last;
  assign take     = o_valid && out_ready;
  assign out_free = !o_valid || (take && done_cur);

  // sequence through the words of the current job
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (out_free) begin
      o_valid <= job.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      o_job        <= job;
      o_phase_byte <= job.has_byte;
      o_tidx       <= '0;
    end else if (take) begin
      if (o_phase_byte) begin
        o_phase_byte <= 1'b0;
      end else begin
        o_tidx <= o_tidx + 3'd1;
      end
    end
  end

  assign out_valid = o_valid;
  assign out_byte  = o_phase_byte ? o_job.data : trailer_byte(o_job.mode, o_job.value, o_tidx);
  assign out_last  = !o_phase_byte && tr_last;

endmodule

@@ sv/frame_check_trailer_appender_top.sv @@
// frame_check_trailer_appender_top: register port, delay line, check unit
// and output stage. Depends on fcta_pkg, fcta_in_if, fcta_out_if,
// fcta_delay_line, fcta_check_unit and fcta_out_emit.
//   channel  | dir | fields                | handshake
//   in_ch    | in  | data_byte, frame_end  | valid/ready
//   out_ch   | out | out_byte, out_last    | valid/ready
//   apb      | in  | check_mode/skip_*     | psel/penable, pready high
//
// One input word per cycle in steady state; each word gives one output word,
// the end word adds 1, 2 or 5 trailer words, sent one per cycle unless stalled.
// Lowering skip_tail mid-frame makes the next word release the surplus held
// bytes one per cycle unless stalled, input held, via the one memory read port.
// Synchronous reset; no clearing pass, the delay memory is never read unwritten.
// Output stalls back up through the check stage to in_ch.ready.
module frame_check_trailer_appender_top import fcta_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  fcta_in_if.sink           in_ch,
  fcta_out_if.source        out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t        cfg;
  reg_idx_t    reg_idx;
  logic        cfg_wr;
  logic        mode_wr;
  rel_op_t     dl_op;
  dl_stat_t    dl_stat;
  logic [7:0]  rd_data;
  logic        adv;
  logic        out_free;
  emit_job_t   job;
  logic [15:0] chk_acc;

  // register port
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign mode_wr = cfg_wr && (reg_idx == REG_CHECK_MODE);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode      <= MODE_CRC16;
      cfg.skip_head <= '0;
      cfg.skip_tail <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_CHECK_MODE: cfg.mode      <= mode_t'(pwdata[1:0]);
        REG_SKIP_HEAD:  cfg.skip_head <= pwdata[7:0];
        REG_SKIP_TAIL:  cfg.skip_tail <= pwdata[TAIL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_CHECK_MODE: prdata = {30'd0, cfg.mode};
      REG_SKIP_HEAD:  prdata = {24'd0, cfg.skip_head};
      REG_SKIP_TAIL:  prdata = {{(32 - TAIL_W){1'b0}}, cfg.skip_tail};
      default:        prdata = '0;
    endcase
  end

  // datapath
  fcta_delay_line u_delay (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_ch.valid),
    .in_data  (in_ch.data_byte),
    .in_end   (in_ch.frame_end),
    .in_ready (in_ch.ready),
    .adv      (adv),
    .op       (dl_op),
    .rd_data  (rd_data),
    .stat     (dl_stat)
  );

  fcta_check_unit u_check (
    .clk      (clk),
    .rst      (rst),
    .mode     (cfg.mode),
    .mode_wr  (mode_wr),
    .wr_mode  (mode_t'(pwdata[1:0])),
    .op_in    (dl_op),
    .rd_data  (rd_data),
    .out_free (out_free),
    .adv      (adv),
    .job      (job),
    .acc_out  (chk_acc)
  );

  fcta_out_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .job       (job),
    .out_free  (out_free),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_byte  (out_ch.out_byte),
    .out_last  (out_ch.out_last)
  );

  // checks
  a_drain_holds_input: assert property (@(posedge clk) disable iff (rst)
    dl_stat.draining |-> !in_ch.ready)
    else $error("input taken while draining delay line");

  a_mode_write_inits: assert property (@(posedge clk) disable iff (rst)
    mode_wr |=> (chk_acc == init_value(cfg.mode)))
    else $error("accumulator not reinitialized after mode write");

  a_end_clears_fill: assert property (@(posedge clk) disable iff (rst)
    (dl_op.valid && dl_op.end_frame) |=> (dl_stat.fill == '0))
    else $error("delay line not cleared at frame end");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    dl_stat.fill <= FILL_W'(MAX_TAIL))
    else $error("delay fill above capacity");

endmodule
